/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SVC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SVC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/svc_pkg.sv */
// ----------------------------------------------------------------------------
// svc_pkg
// Types and constants of the signed varint codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svc_pkg;

  // request opcodes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_MAG  = 2'd1;
  localparam logic [1:0] ERR_LONG = 2'd2;

  // field widths
  localparam int MAG_W = 27;
  localparam int VAL_W = 28;

  // job queue geometry
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  // one job handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   data;   // magnitude for encode, value for decode
    logic               neg;
    logic [1:0]         nlast;  // index of the final result of the job
    logic [1:0]         err;
  } job_t;

endpackage

/* sv/svc_front.sv */
// ----------------------------------------------------------------------------
// svc_front
// Accepts requests, keeps the decoder state and classifies each encode request
// and each finished decode into one back-end job (encode, decoded value or error).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svc_front import svc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic        opcode,
  input  logic [31:0] value_in,
  input  logic        negate,
  input  logic [7:0]  byte_in,
  output logic        job_push,
  output job_t        job
);

  logic [MAG_W-1:0] accum_r, accum_nxt, acc_upd;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             sign_r, sign_nxt, sign_upd;
  logic             busy_r, busy_nxt;
  logic [31:0]      mag;
  logic [VAL_W-1:0] mag_ext;

  // magnitude of the encode operand
  assign mag     = negate ? (~value_in + 32'd1) : value_in;
  assign mag_ext = {1'b0, acc_upd};

  // classify the request and advance the decoder
  always_comb begin
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    sign_nxt  = sign_r;
    busy_nxt  = busy_r;
    acc_upd   = accum_r;
    sign_upd  = sign_r;
    job_push  = 1'b0;
    job       = '0;
    job.kind  = KIND_BYTE;
    if (acc) begin
      if (opcode == OP_ENCODE) begin
        job_push = 1'b1;
        if (mag[31:MAG_W] != '0) begin
          job.kind = KIND_ERROR;
          job.err  = ERR_MAG;
        end else begin
          job.kind = KIND_BYTE;
          job.data = {1'b0, mag[MAG_W-1:0]};
          job.neg  = negate;
          if (mag[26:20] != '0)      job.nlast = 2'd3;
          else if (mag[19:13] != '0) job.nlast = 2'd2;
          else if (mag[12:6] != '0)  job.nlast = 2'd1;
          else                       job.nlast = 2'd0;
        end
      end else if (busy_r && (cnt_r == 2'd3)) begin
        // fifth byte: drop the number and flag it
        job_push  = 1'b1;
        job.kind  = KIND_ERROR;
        job.err   = ERR_LONG;
        accum_nxt = '0;
        cnt_nxt   = '0;
        sign_nxt  = 1'b0;
        busy_nxt  = 1'b0;
      end else begin
        if (!busy_r) begin
          sign_upd = byte_in[6];
          acc_upd  = {21'd0, byte_in[5:0]};
          cnt_nxt  = 2'd0;
        end else begin
          case (cnt_r)
            2'd0:    acc_upd = accum_r | {14'd0, byte_in[6:0], 6'd0};
            2'd1:    acc_upd = accum_r | {7'd0, byte_in[6:0], 13'd0};
            default: acc_upd = accum_r | {byte_in[6:0], 20'd0};
          endcase
          cnt_nxt = cnt_r + 2'd1;
        end
        if (byte_in[7]) begin
          accum_nxt = acc_upd;
          sign_nxt  = sign_upd;
          busy_nxt  = 1'b1;
        end else begin
          job_push  = 1'b1;
          job.kind  = KIND_VALUE;
          job.data  = sign_upd ? (~mag_ext + 28'd1) : mag_ext;
          job.neg   = sign_upd;
          accum_nxt = '0;
          cnt_nxt   = '0;
          sign_nxt  = 1'b0;
          busy_nxt  = 1'b0;
        end
      end
    end
  end

  // hold decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      cnt_r   <= '0;
      sign_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
      sign_r  <= sign_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

/* sv/svc_jobq.sv */
// ----------------------------------------------------------------------------
// svc_jobq
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svc_jobq import svc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t             mem_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_r, rd_r;
  logic [JQ_CW-1:0] cnt_r;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == JQ_CW'(JQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  // store jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + JQ_AW'(1);
      if (do_pop)  rd_r <= rd_r + JQ_AW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + JQ_CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - JQ_CW'(1);
    end
  end

  `SVC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= JQ_CW'(JQ_DEPTH), "job queue count overrun")
  `SVC_ASSERT_NXT(a_push_grow, do_push && !do_pop, cnt_r == $past(cnt_r) + JQ_CW'(1),
    "job queue count missed a push")
  `SVC_ASSERT_NXT(a_ptr_gap, do_push && do_pop, (wr_r - rd_r) == ($past(wr_r) - $past(rd_r)),
    "job queue pointers drifted")

endmodule

/* sv/svc_back.sv */
// ----------------------------------------------------------------------------
// svc_back
// Expands queued jobs into result items in an output register that the
// consumer drains, one per cycle while the consumer keeps popping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svc_back import svc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  job_t                    q_head,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic [1:0]              kind,
  output logic [7:0]              byte_out,
  output logic signed [VAL_W-1:0] decoded_value,
  output logic                    is_negative,
  output logic                    last,
  output logic [1:0]              error_code
);

  logic               valid_r;
  logic [1:0]         idx_r;
  logic [1:0]         kind_r;
  logic [7:0]         byte_r;
  logic [VAL_W-1:0]   value_r;
  logic               neg_r, last_r;
  logic [1:0]         err_r;
  logic               ld, fin, cont;
  logic [6:0]         chunk;
  logic [7:0]         enc_byte;

  // load the output register when it is free or being drained
  assign ld    = !q_empty && (!valid_r || pop);
  assign fin   = (idx_r == q_head.nlast);
  assign q_pop = ld && fin;
  assign cont  = !fin;

  // pick the magnitude slice of the current byte
  always_comb begin
    case (idx_r)
      2'd0:    chunk = {q_head.neg, q_head.data[5:0]};
      2'd1:    chunk = q_head.data[12:6];
      2'd2:    chunk = q_head.data[19:13];
      default: chunk = q_head.data[26:20];
    endcase
    enc_byte = {cont, chunk};
  end

  // hold the result register and the byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (ld) begin
        valid_r <= 1'b1;
        idx_r   <= fin ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ld) begin
      kind_r  <= q_head.kind;
      last_r  <= fin;
      byte_r  <= (q_head.kind == KIND_BYTE) ? enc_byte : 8'd0;
      value_r <= (q_head.kind == KIND_VALUE) ? q_head.data : '0;
      neg_r   <= (q_head.kind == KIND_VALUE) ? q_head.neg : 1'b0;
      err_r   <= (q_head.kind == KIND_ERROR) ? q_head.err : ERR_NONE;
    end
  end

  assign empty         = !valid_r;
  assign kind          = kind_r;
  assign byte_out      = byte_r;
  assign decoded_value = value_r;
  assign is_negative   = neg_r;
  assign last          = last_r;
  assign error_code    = err_r;

  `SVC_ASSERT_IMP(a_idx_bound, !q_empty, idx_r <= q_head.nlast, "byte index past job end")
  `SVC_ASSERT_NXT(a_pop_last, q_pop, valid_r && last_r, "job retired without last result")
  `SVC_ASSERT_IMP(a_idle_idx, q_empty, idx_r == 2'd0, "byte index left over without a job")

endmodule

/* sv/signed_varint_codec.sv */
// ----------------------------------------------------------------------------
// signed_varint_codec
// Sign-magnitude varint codec: encodes values into 1 to 4 bytes and decodes
// a byte stream back into values, with a front end, job queue and back end.
// ----------------------------------------------------------------------------
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+------------------
//  request   | in_opcode in_value_in in_negate in_byte_in   | in_push / in_full
//  result    | out_kind out_byte_out out_decoded_value      | out_pop / out_empty
//            | out_is_negative out_last out_error_code      |
//
//  A request is taken when in_push is high and in_full is low; decode bytes
//  can arrive every cycle while in_full is low. An encode request yields
//  1 to 4 results, a decode request 0 or 1, and the back end delivers one
//  result per cycle while out_pop drains it, so an encode holds the back end
//  until its last byte is loaded. in_full rises when the four-entry job queue
//  is full; out_empty low means a result is waiting in the output register.
//  Synchronous reset clears decoder, queue and the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_varint_codec import svc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_opcode,
  input  logic [31:0]             in_value_in,
  input  logic                    in_negate,
  input  logic [7:0]              in_byte_in,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_byte_out,
  output logic signed [VAL_W-1:0] out_decoded_value,
  output logic                    out_is_negative,
  output logic                    out_last,
  output logic [1:0]              out_error_code
);

  logic acc, job_push, q_pop, q_empty, q_full;
  job_t job, q_head;

  // accept a request while the job queue has room
  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  svc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .opcode   (in_opcode),
    .value_in (in_value_in),
    .negate   (in_negate),
    .byte_in  (in_byte_in),
    .job_push (job_push),
    .job      (job)
  );

  svc_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  svc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (out_pop),
    .empty         (out_empty),
    .kind          (out_kind),
    .byte_out      (out_byte_out),
    .decoded_value (out_decoded_value),
    .is_negative   (out_is_negative),
    .last          (out_last),
    .error_code    (out_error_code)
  );

endmodule

/* sim/signed_varint_codec_tb.sv */
// ----------------------------------------------------------------------------
// signed_varint_codec_tb
// Self-checking bench for the signed varint codec. A queue of requests feeds
// a clocked driver, a clocked monitor pops results and compares every field
// with a local model of the encoder and decoder. Both sides idle in bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_varint_codec_tb;
  import svc_pkg::*;

  localparam int RANDOM_REQS = 150;
  localparam int TAIL_REQS   = 30;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 16;
  localparam logic [31:0] MAG_LIMIT = 32'h07FF_FFFF;

  typedef struct packed {
    logic        op;
    logic [31:0] value;
    logic        neg;
    logic [7:0]  byte_v;
  } codec_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_out;
    logic [27:0] value;
    logic        negf;
    logic        last;
    logic [1:0]  err;
  } codec_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_opcode = 1'b0;
  logic [31:0] in_value_in = '0;
  logic in_negate = 1'b0;
  logic [7:0] in_byte_in = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte_out;
  logic signed [VAL_W-1:0] out_decoded_value;
  logic out_is_negative;
  logic out_last;
  logic [1:0] out_error_code;

  codec_req_t pending_reqs[$];
  codec_res_t expected_results[$];
  codec_req_t cur_req;

  // decoder shadow state
  logic [MAG_W-1:0] dec_accum = '0;
  logic [1:0]       dec_count = '0;
  logic             dec_sign = 1'b0;
  logic             dec_busy = 1'b0;

  int total_reqs = 0;
  int accepted_reqs = 0;
  int enc_reqs = 0;
  int dec_reqs = 0;
  int n_bytes = 0;
  int n_values = 0;
  int n_errors = 0;
  int fail_count = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit tail_phase = 1'b0;
  bit timed_out = 1'b0;

  signed_varint_codec i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_opcode         (in_opcode),
    .in_value_in       (in_value_in),
    .in_negate         (in_negate),
    .in_byte_in        (in_byte_in),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_kind          (out_kind),
    .out_byte_out      (out_byte_out),
    .out_decoded_value (out_decoded_value),
    .out_is_negative   (out_is_negative),
    .out_last          (out_last),
    .out_error_code    (out_error_code)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  function automatic codec_res_t make_result(kind_t k, logic [7:0] b, logic [27:0] v,
                                             logic ng, logic lst, logic [1:0] e);
    codec_res_t r;
    r.kind     = k;
    r.byte_out = b;
    r.value    = v;
    r.negf     = ng;
    r.last     = lst;
    r.err      = e;
    return r;
  endfunction

  // split a magnitude into its varint bytes, first byte in the low lane
  function automatic int varint_bytes(input logic [MAG_W-1:0] mag, input logic ng,
                                      output logic [31:0] seq);
    logic [MAG_W-1:0] rest;
    logic [7:0] b;
    int n;
    bit done;
    seq  = '0;
    b    = {1'b0, ng, mag[5:0]};
    rest = mag >> 6;
    n    = 0;
    done = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!done) begin
        if (rest != 0) b[7] = 1'b1;
        seq[8*i +: 8] = b;
        n    = i + 1;
        done = (rest == 0);
        b    = {1'b0, rest[6:0]};
        rest = rest >> 7;
      end
    end
    return n;
  endfunction

  // work out the results of one accepted request and queue them
  task automatic predict_codec(input codec_req_t r);
    logic [31:0] mag;
    logic [31:0] seq;
    logic [27:0] v;
    int n;
    if (r.op == OP_ENCODE) begin
      mag = r.neg ? (~r.value + 32'd1) : r.value;
      if (mag > MAG_LIMIT) begin
        expected_results.push_back(make_result(KIND_ERROR, '0, '0, 1'b0, 1'b1, ERR_MAG));
      end else begin
        n = varint_bytes(mag[MAG_W-1:0], r.neg, seq);
        for (int i = 0; i < n; i++)
          expected_results.push_back(make_result(KIND_BYTE, seq[8*i +: 8], '0, 1'b0,
                                                 (i == n - 1), ERR_NONE));
      end
    end else if (dec_busy && dec_count == 2'd3) begin
      // fifth byte: drop the number in progress
      dec_accum = '0;
      dec_count = '0;
      dec_sign  = 1'b0;
      dec_busy  = 1'b0;
      expected_results.push_back(make_result(KIND_ERROR, '0, '0, 1'b0, 1'b1, ERR_LONG));
    end else begin
      if (!dec_busy) begin
        dec_sign  = r.byte_v[6];
        dec_accum = MAG_W'(r.byte_v[5:0]);
        dec_count = '0;
      end else begin
        dec_accum = dec_accum | (MAG_W'(r.byte_v[6:0]) << (6 + 7 * dec_count));
        dec_count = dec_count + 2'd1;
      end
      if (r.byte_v[7]) begin
        dec_busy = 1'b1;
      end else begin
        v = dec_sign ? (28'd0 - {1'b0, dec_accum}) : {1'b0, dec_accum};
        expected_results.push_back(make_result(KIND_VALUE, '0, v, dec_sign, 1'b1,
                                               ERR_NONE));
        dec_accum = '0;
        dec_count = '0;
        dec_sign  = 1'b0;
        dec_busy  = 1'b0;
      end
    end
  endtask

  // request driver: hold until taken, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_codec(cur_req);
        accepted_reqs++;
        if (cur_req.op == OP_ENCODE) enc_reqs++;
        else dec_reqs++;
      end
      if (!in_push || !in_full) begin
        if (in_gap != 0) begin
          in_gap--;
          in_push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_opcode   <= cur_req.op;
          in_value_in <= cur_req.value;
          in_negate   <= cur_req.neg;
          in_byte_in  <= cur_req.byte_v;
          in_push     <= 1'b1;
          tail_phase = (pending_reqs.size() < TAIL_REQS);
          if (!tail_phase && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 16);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare with the oldest expectation, stall in bursts
  always @(posedge clk) begin
    codec_res_t exp_r;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte %h value %h",
                   $time, out_kind, out_byte_out, out_decoded_value);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          case (exp_r.kind)
            KIND_BYTE:  n_bytes++;
            KIND_VALUE: n_values++;
            default:    n_errors++;
          endcase
          if (out_kind !== exp_r.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, exp_r.kind, out_kind);
            fail_count++;
          end
          if (out_byte_out !== exp_r.byte_out) begin
            $display("%0t: byte_out mismatch, expected %h, actual %h",
                     $time, exp_r.byte_out, out_byte_out);
            fail_count++;
          end
          if (out_decoded_value !== exp_r.value) begin
            $display("%0t: decoded_value mismatch, expected %h, actual %h",
                     $time, exp_r.value, out_decoded_value);
            fail_count++;
          end
          if (out_is_negative !== exp_r.negf) begin
            $display("%0t: is_negative mismatch, expected %b, actual %b",
                     $time, exp_r.negf, out_is_negative);
            fail_count++;
          end
          if (out_last !== exp_r.last) begin
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, exp_r.last, out_last);
            fail_count++;
          end
          if (out_error_code !== exp_r.err) begin
            $display("%0t: error_code mismatch, expected %0d, actual %0d",
                     $time, exp_r.err, out_error_code);
            fail_count++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (!tail_phase && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 16);
      end
    end
  end

  task automatic add_encode(input logic [31:0] value, input logic ng);
    codec_req_t r;
    r.op     = OP_ENCODE;
    r.value  = value;
    r.neg    = ng;
    r.byte_v = 8'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic add_decode(input logic [7:0] b);
    codec_req_t r;
    r.op     = OP_DECODE;
    r.value  = $urandom;
    r.neg    = 1'($urandom);
    r.byte_v = b;
    pending_reqs.push_back(r);
  endtask

  // random magnitude of random bit length up to 27 bits
  function automatic logic [31:0] rand_mag();
    int w;
    w = $urandom_range(0, MAG_W);
    return $urandom & 32'((64'd1 << w) - 1);
  endfunction

  initial begin
    int n;
    int stall;
    logic [31:0] mag;
    logic [31:0] seq;
    logic ng;

    // directed: byte-length boundaries and range limits of the encoder
    add_encode(32'h0000_0000, 1'b0);
    add_encode(32'h0000_003F, 1'b0);
    add_encode(32'h0000_0040, 1'b0);
    add_encode(32'h0000_2000, 1'b0);
    add_encode(32'h0010_0000, 1'b0);
    add_encode(32'h07FF_FFFF, 1'b0);
    add_encode(32'h0800_0000, 1'b0);
    add_encode(32'hFFFF_FFFF, 1'b0);
    // negative zero, smallest and largest negative magnitudes, one too large
    add_encode(32'h0000_0000, 1'b1);
    add_encode(32'hFFFF_FFFF, 1'b1);
    add_encode(32'hF800_0001, 1'b1);
    add_encode(32'hF800_0000, 1'b1);
    // directed decode: zero, negative zero, one-byte minimum, four-byte minimum
    add_decode(8'h00);
    add_decode(8'h40);
    add_decode(8'h7F);
    add_decode(8'hFF);
    add_decode(8'hFF);
    add_decode(8'hFF);
    add_decode(8'h7F);
    // fifth byte with a clear continuation bit
    add_decode(8'h80);
    add_decode(8'h80);
    add_decode(8'h80);
    add_decode(8'h80);
    add_decode(8'h00);
    // encode in the middle of a number being decoded
    add_decode(8'h81);
    add_encode(32'h0000_0005, 1'b0);
    add_decode(8'h01);

    // random: mostly well-formed numbers, some overlong streams and noise
    n = pending_reqs.size();
    while (pending_reqs.size() < n + RANDOM_REQS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          ng = 1'($urandom);
          if ($urandom_range(0, 7) == 0) begin
            add_encode($urandom, ng);
          end else begin
            mag = rand_mag();
            add_encode(ng ? (~mag + 32'd1) : mag, ng);
          end
        end
        4, 5, 6, 7: begin
          mag = rand_mag();
          ng  = 1'($urandom);
          stall = varint_bytes(mag[MAG_W-1:0], ng, seq);
          for (int i = 0; i < stall; i++) begin
            add_decode(seq[8*i +: 8]);
            if (i == 0 && stall > 1 && $urandom_range(0, 3) == 0)
              add_encode(rand_mag(), 1'b0);
          end
        end
        8: begin
          for (int i = 0; i < 4; i++) add_decode(8'($urandom) | 8'h80);
          add_decode(8'($urandom));
        end
        default: add_decode(8'($urandom));
      endcase
    end
    total_reqs = pending_reqs.size();

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        while (accepted_reqs != total_reqs || expected_results.size() != 0)
          @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
      end
      begin
        // watchdog: count cycles without any accepted request or result
        stall = 0;
        while (stall < STALL_LIMIT) begin
          @(posedge clk);
          if ((in_push && !in_full) || (out_pop && !out_empty)) stall = 0;
          else stall++;
        end
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    $display("Run covered %0d encode and %0d decode requests of %0d queued.",
             enc_reqs, dec_reqs, total_reqs);
    $display("Checked %0d encoded bytes, %0d decoded values and %0d errors%s.",
             n_bytes, n_values, n_errors, timed_out ? ", stopped by watchdog" : "");
    if (fail_count == 0 && !timed_out && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
